// File: rtl/core/mtq_pkg.sv
// Shared types, constants and register codes for the motion/touch qualifier.
package mtq_pkg;

    // Width of the wrapping millisecond time base
    localparam int TIME_W = 32;
    // Compare width that holds both time values and 32-bit registers
    localparam int WIDE_W = (TIME_W > 32) ? TIME_W : 32;

    // APB register file geometry
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register reset values
    localparam logic [31:0] WARMUP_RST   = 32'd25000;
    localparam logic [31:0] CONFIRM_RST  = 32'd250;
    localparam logic [31:0] HOLD_RST     = 32'd5000;
    localparam logic [31:0] COOLDOWN_RST = 32'd10000;
    localparam logic [15:0] TOUCH_DB_RST = 16'd50;

    typedef logic [TIME_W-1:0] time_t;

    // Register index, taken from paddr word address
    typedef enum logic [2:0] {
        REG_WARMUP   = 3'd0,
        REG_CONFIRM  = 3'd1,
        REG_HOLD     = 3'd2,
        REG_COOLDOWN = 3'd3,
        REG_TOUCH_DB = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [31:0] warmup_ms;
        logic [31:0] confirm_ms;
        logic [31:0] hold_ms;
        logic [31:0] cooldown_ms;
        logic [15:0] touch_debounce_ms;
    } cfg_t;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        motion_level;
        logic        touch_level;
    } in_item_t;

    typedef struct packed {
        logic motion_seen;
        logic alarm_on;
        logic touch_seen;
    } out_item_t;

endpackage

// File: rtl/core/mtq_cfg_regs.sv
// APB configuration register file for the motion/touch qualifier.
module mtq_cfg_regs
    import mtq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Decode the write transaction
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_WARMUP:   cfg_next.warmup_ms         = pwdata;
                REG_CONFIRM:  cfg_next.confirm_ms        = pwdata;
                REG_HOLD:     cfg_next.hold_ms           = pwdata;
                REG_COOLDOWN: cfg_next.cooldown_ms       = pwdata;
                REG_TOUCH_DB: cfg_next.touch_debounce_ms = pwdata[15:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold register values
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.warmup_ms         <= WARMUP_RST;
            cfg_reg.confirm_ms        <= CONFIRM_RST;
            cfg_reg.hold_ms           <= HOLD_RST;
            cfg_reg.cooldown_ms       <= COOLDOWN_RST;
            cfg_reg.touch_debounce_ms <= TOUCH_DB_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Return the addressed register
    always_comb
    begin
        unique case (idx)
            REG_WARMUP:   prdata = cfg_reg.warmup_ms;
            REG_CONFIRM:  prdata = cfg_reg.confirm_ms;
            REG_HOLD:     prdata = cfg_reg.hold_ms;
            REG_COOLDOWN: prdata = cfg_reg.cooldown_ms;
            REG_TOUCH_DB: prdata = {16'd0, cfg_reg.touch_debounce_ms};
            default:      prdata = '0;
        endcase
    end

endmodule

// File: rtl/core/mtq_qualifier.sv
// Qualifier state and single-pass update for one sample.
module mtq_qualifier
    import mtq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output out_item_t result
);

    logic  motion_timing_reg, motion_timing_next;
    time_t motion_start_reg,  motion_start_next;
    time_t trigger_time_reg,  trigger_time_next;
    time_t alarm_end_reg,     alarm_end_next;
    logic  touch_timing_reg,  touch_timing_next;
    time_t touch_start_reg,   touch_start_next;
    logic  motion_flag_reg,   motion_flag_next;
    logic  alarm_flag_reg,    alarm_flag_next;
    logic  touch_flag_reg,    touch_flag_next;

    time_t now;
    logic  watched;
    logic  motion_done;
    logic  touch_done;
    logic  hold_done;
    logic  new_trigger;

    assign now = TIME_W'(item.now_ms);

    // Compare elapsed times in parallel
    always_comb
    begin
        watched = (WIDE_W'(now) >= WIDE_W'(cfg.warmup_ms)) &&
                  (WIDE_W'(time_t'(now - alarm_end_reg)) >= WIDE_W'(cfg.cooldown_ms));
        motion_done = WIDE_W'(time_t'(now - motion_start_reg)) >= WIDE_W'(cfg.confirm_ms);
        hold_done   = WIDE_W'(time_t'(now - trigger_time_reg)) >= WIDE_W'(cfg.hold_ms);
        touch_done  = WIDE_W'(time_t'(now - touch_start_reg)) >=
                      WIDE_W'(cfg.touch_debounce_ms);
    end

    // Advance motion, alarm and touch state
    always_comb
    begin
        motion_timing_next = motion_timing_reg;
        motion_start_next  = motion_start_reg;
        trigger_time_next  = trigger_time_reg;
        alarm_end_next     = alarm_end_reg;
        touch_timing_next  = touch_timing_reg;
        touch_start_next   = touch_start_reg;
        motion_flag_next   = motion_flag_reg;
        alarm_flag_next    = alarm_flag_reg;
        touch_flag_next    = touch_flag_reg;
        new_trigger        = 1'b0;

        if (watched && item.motion_level)
        begin
            if (!motion_timing_reg)
            begin
                motion_timing_next = 1'b1;
                motion_start_next  = now;
            end
            else if (motion_done && !alarm_flag_reg)
            begin
                motion_flag_next  = 1'b1;
                trigger_time_next = now;
                alarm_flag_next   = 1'b1;
                new_trigger       = 1'b1;
            end
        end
        else
        begin
            motion_timing_next = 1'b0;
            motion_start_next  = '0;
            motion_flag_next   = 1'b0;
        end

        // A fresh trigger has zero elapsed time, so it expires only on zero hold
        if (new_trigger ? (cfg.hold_ms == 32'd0) : (alarm_flag_reg && hold_done))
        begin
            alarm_flag_next = 1'b0;
            alarm_end_next  = now;
        end

        if (item.touch_level)
        begin
            if (!touch_timing_reg)
            begin
                touch_timing_next = 1'b1;
                touch_start_next  = now;
            end
            else if (touch_done)
            begin
                touch_flag_next = 1'b1;
            end
        end
        else
        begin
            touch_timing_next = 1'b0;
            touch_start_next  = '0;
            touch_flag_next   = 1'b0;
        end
    end

    assign result.motion_seen = motion_flag_next;
    assign result.alarm_on    = alarm_flag_next;
    assign result.touch_seen  = touch_flag_next;

    // Hold state, update on each processed sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motion_timing_reg <= 1'b0;
            motion_start_reg  <= '0;
            trigger_time_reg  <= '0;
            alarm_end_reg     <= '0;
            touch_timing_reg  <= 1'b0;
            touch_start_reg   <= '0;
            motion_flag_reg   <= 1'b0;
            alarm_flag_reg    <= 1'b0;
            touch_flag_reg    <= 1'b0;
        end
        else if (fire)
        begin
            motion_timing_reg <= motion_timing_next;
            motion_start_reg  <= motion_start_next;
            trigger_time_reg  <= trigger_time_next;
            alarm_end_reg     <= alarm_end_next;
            touch_timing_reg  <= touch_timing_next;
            touch_start_reg   <= touch_start_next;
            motion_flag_reg   <= motion_flag_next;
            alarm_flag_reg    <= alarm_flag_next;
            touch_flag_reg    <= touch_flag_next;
        end
    end

endmodule

// File: rtl/core/motion_touch_qualifier.sv
// Motion/touch qualifier top level: input register, update logic, result register.
// Path: a sample accepted into the input register is processed once the result register
// is free or being emptied, and its flags are then captured in the result register.
// Throughput: one sample per cycle while out_ready stays high; the state update between
// the input and result registers is a single pass of subtract-and-compare logic.
// Reset: rst_n clears all timing state, flags and pipeline valids, and loads the
// configuration registers with their default values.
module motion_touch_qualifier
    import mtq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_item_t          in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output out_item_t         out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    in_item_t  in_reg;
    logic      in_vld_reg,  in_vld_next;
    out_item_t out_reg;
    logic      out_vld_reg, out_vld_next;
    out_item_t result;
    cfg_t      cfg;
    logic      out_free;
    logic      fire;
    logic      in_take;

    mtq_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mtq_qualifier u_qual (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (in_reg),
        .cfg    (cfg),
        .result (result)
    );

    // Pipeline handshake
    assign out_free  = !out_vld_reg || out_ready;
    assign fire      = in_vld_reg && out_free;
    assign in_ready  = !in_vld_reg || out_free;
    assign in_take   = in_valid && in_ready;
    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_take)
            in_vld_next = 1'b1;
        else if (fire)
            in_vld_next = 1'b0;

        out_vld_next = out_vld_reg;
        if (fire)
            out_vld_next = 1'b1;
        else if (out_ready)
            out_vld_next = 1'b0;
    end

    // Hold valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_reg <= in_data;
        if (fire)
            out_reg <= result;
    end

    // A processed sample always lands in the result register
    a_fire_lands: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_vld_reg)
        else $error("processed sample did not reach result register");

    // A low motion line never reports confirmed motion
    a_motion_low: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !in_reg.motion_level) |=> !out_reg.motion_seen)
        else $error("motion reported on low motion line");

    // A low touch line never reports a touch
    a_touch_low: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !in_reg.touch_level) |=> !out_reg.touch_seen)
        else $error("touch reported on low touch line");

endmodule

// File: bench/tb_top.sv
// Self-checking testbench for the motion/touch qualifier: stimulus, prediction, checking.
`timescale 1ns / 100ps

module tb_top;
    import mtq_pkg::*;

    localparam int QUIET_LIMIT = 1000;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    in_item_t          in_data = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    out_item_t         out_data;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    motion_touch_qualifier DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Samples waiting to be sent, and flags expected back
    in_item_t  sample_q[$];
    out_item_t flags_q[$];
    int        err_cnt = 0;
    bit        idling_on = 1'b1;

    // Predictor copy of the registers and qualifier state
    cfg_t  mdl_cfg;
    logic  st_mot_timing;
    time_t st_mot_start;
    time_t st_trig_time;
    time_t st_alarm_end;
    logic  st_tch_timing;
    time_t st_tch_start;
    logic  st_motion;
    logic  st_alarm;
    logic  st_touch;

    // Advance the predicted state by one sample and return the expected flags
    function automatic out_item_t qualify_sample(in_item_t s);
        time_t     now;
        logic      watched;
        out_item_t r;
        now = s.now_ms;
        watched = (now >= mdl_cfg.warmup_ms) &&
                  (time_t'(now - st_alarm_end) >= mdl_cfg.cooldown_ms);

        // Confirm motion, trigger alarm if none is active
        if (watched && s.motion_level)
        begin
            if (!st_mot_timing)
            begin
                st_mot_timing = 1'b1;
                st_mot_start = now;
            end
            else if (time_t'(now - st_mot_start) >= mdl_cfg.confirm_ms && !st_alarm)
            begin
                st_motion = 1'b1;
                st_trig_time = now;
                st_alarm = 1'b1;
            end
        end
        else
        begin
            st_mot_timing = 1'b0;
            st_mot_start = '0;
            st_motion = 1'b0;
        end

        // Expire alarm regardless of watch state; start cooldown
        if (st_alarm && time_t'(now - st_trig_time) >= mdl_cfg.hold_ms)
        begin
            st_alarm = 1'b0;
            st_alarm_end = now;
        end

        // Debounce touch
        if (s.touch_level)
        begin
            if (!st_tch_timing)
            begin
                st_tch_timing = 1'b1;
                st_tch_start = now;
            end
            else if (time_t'(now - st_tch_start) >= {16'd0, mdl_cfg.touch_debounce_ms})
                st_touch = 1'b1;
        end
        else
        begin
            st_tch_timing = 1'b0;
            st_tch_start = '0;
            st_touch = 1'b0;
        end

        r.motion_seen = st_motion;
        r.alarm_on = st_alarm;
        r.touch_seen = st_touch;
        return r;
    endfunction

    // Driver: present queued samples, predict on each accepted transaction
    int unsigned send_gap = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                flags_q.push_back(qualify_sample(in_data));
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (sample_q.size() > 0 && idling_on && $urandom_range(0, 7) == 0)
                begin
                    send_gap = $urandom_range(0, 17);
                    in_valid <= 1'b0;
                end
                else if (sample_q.size() > 0)
                begin
                    in_data <= sample_q.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: stall at random, check each result transaction against the oldest expectation
    int unsigned stall_cnt = 0;
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (flags_q.size() == 0)
                begin
                    $error("unexpected result transaction: %b", out_data);
                    err_cnt++;
                end
                else
                begin
                    want = flags_q.pop_front();
                    if (out_data.motion_seen !== want.motion_seen)
                    begin
                        $error("motion_seen: expected %0b, got %0b",
                               want.motion_seen, out_data.motion_seen);
                        err_cnt++;
                    end
                    if (out_data.alarm_on !== want.alarm_on)
                    begin
                        $error("alarm_on: expected %0b, got %0b",
                               want.alarm_on, out_data.alarm_on);
                        err_cnt++;
                    end
                    if (out_data.touch_seen !== want.touch_seen)
                    begin
                        $error("touch_seen: expected %0b, got %0b",
                               want.touch_seen, out_data.touch_seen);
                        err_cnt++;
                    end
                end
            end
            if (stall_cnt > 0)
            begin
                stall_cnt--;
                out_ready <= 1'b0;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                stall_cnt = $urandom_range(0, 17);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog: end the run after too long with no transaction anywhere
    int unsigned quiet_cnt = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
                quiet_cnt = 0;
            else
                quiet_cnt++;
            if (quiet_cnt >= QUIET_LIMIT)
            begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    // Register write over APB: setup then access cycle; mirror into the predictor
    task automatic cfg_write(reg_idx_t idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_WARMUP:   mdl_cfg.warmup_ms = val;
            REG_CONFIRM:  mdl_cfg.confirm_ms = val;
            REG_HOLD:     mdl_cfg.hold_ms = val;
            REG_COOLDOWN: mdl_cfg.cooldown_ms = val;
            REG_TOUCH_DB: mdl_cfg.touch_debounce_ms = val[15:0];
            default: ;
        endcase
    endtask

    task automatic cfg_all(logic [31:0] wu, logic [31:0] cf, logic [31:0] hd,
                           logic [31:0] cd, logic [15:0] db);
        cfg_write(REG_WARMUP, wu);
        cfg_write(REG_CONFIRM, cf);
        cfg_write(REG_HOLD, hd);
        cfg_write(REG_COOLDOWN, cd);
        cfg_write(REG_TOUCH_DB, {16'd0, db});
    endtask

    task automatic add_sample(logic [31:0] now, logic mot, logic tch);
        in_item_t s;
        s.now_ms = now;
        s.motion_level = mot;
        s.touch_level = tch;
        sample_q.push_back(s);
    endtask

    // Random walk in time with runs of motion/touch levels; some samples jump anywhere
    time_t walk_now = '0;
    logic  walk_mot = 1'b0;
    logic  walk_tch = 1'b0;
    task automatic add_walk(int count, int unsigned step_max);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 4) == 0)
                walk_mot = ~walk_mot;
            if ($urandom_range(0, 4) == 0)
                walk_tch = ~walk_tch;
            if ($urandom_range(0, 15) == 0)
                add_sample($urandom(), walk_mot, walk_tch);
            else
            begin
                walk_now += $urandom_range(0, step_max);
                add_sample(walk_now, walk_mot, walk_tch);
            end
        end
    endtask

    // Hold until every sample is sent and every result has come back
    task automatic drain();
        while (sample_q.size() != 0 || in_valid || flags_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        mdl_cfg = '{WARMUP_RST, CONFIRM_RST, HOLD_RST, COOLDOWN_RST, TOUCH_DB_RST};
        st_mot_timing = 1'b0;
        st_mot_start = '0;
        st_trig_time = '0;
        st_alarm_end = '0;
        st_tch_timing = 1'b0;
        st_tch_start = '0;
        st_motion = 1'b0;
        st_alarm = 1'b0;
        st_touch = 1'b0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Default registers: warm-up, confirm, hold, cooldown, wrap of the time base
        add_sample(32'd0, 1'b1, 1'b1);
        add_sample(32'd0, 1'b1, 1'b1);
        add_sample(32'd50, 1'b1, 1'b1);
        add_sample(32'd24999, 1'b1, 1'b0);
        add_sample(32'd25000, 1'b1, 1'b0);
        add_sample(32'd25249, 1'b1, 1'b0);
        add_sample(32'd25250, 1'b1, 1'b1);
        add_sample(32'd26000, 1'b1, 1'b1);
        add_sample(32'd30250, 1'b1, 1'b1);
        add_sample(32'd30251, 1'b1, 1'b0);
        add_sample(32'd40250, 1'b1, 1'b0);
        add_sample(32'd40250, 1'b0, 1'b0);
        add_sample(32'hFFFF_FFFF, 1'b1, 1'b1);
        add_sample(32'h0000_0005, 1'b1, 1'b1);
        add_sample(32'h0000_0040, 1'b1, 1'b1);
        drain();

        // All-zero registers: confirm on second sample, alarm ends the same sample
        cfg_all('0, '0, '0, '0, '0);
        add_sample(32'd100, 1'b1, 1'b1);
        add_sample(32'd100, 1'b1, 1'b1);
        add_sample(32'd100, 1'b1, 1'b0);
        add_sample(32'd101, 1'b0, 1'b1);
        drain();

        // All-max registers
        cfg_all('1, '1, '1, '1, '1);
        add_sample(32'hFFFF_FFFF, 1'b1, 1'b1);
        add_sample(32'hFFFF_FFFF, 1'b1, 1'b1);
        add_sample(32'h0000_0000, 1'b0, 1'b1);
        drain();

        // Random: short timings so alarms and cooldowns cycle often
        cfg_all(32'd20, 32'd5, 32'd30, 32'd15, 16'd3);
        walk_now = '0;
        add_walk(250, 4);
        drain();

        cfg_all('0, '0, '0, '0, '0);
        add_walk(100, 2);
        drain();

        // Random timings, walk across the wrap of the time base
        cfg_all($urandom_range(0, 40), $urandom_range(0, 20), $urandom_range(0, 60),
                $urandom_range(0, 40), 16'($urandom_range(0, 10)));
        walk_now = 32'hFFFF_FF80;
        add_walk(250, 4);
        drain();

        cfg_all('1, '1, '1, '1, '1);
        add_walk(80, 1 << 20);
        drain();

        // Last stretch at full rate
        cfg_all(32'd10, 32'd3, 32'd25, 32'd12, 16'd2);
        idling_on = 1'b0;
        add_walk(250, 3);
        drain();

        if (err_cnt == 0 && flags_q.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

// File: motion_touch_qualifier.f
rtl/core/mtq_pkg.sv
rtl/core/mtq_cfg_regs.sv
rtl/core/mtq_qualifier.sv
rtl/core/motion_touch_qualifier.sv
bench/tb_top.sv
